// ----- sv/blank_skip_write_segmenter_core_assert.svh -----
// Assertion macros used by the segmenter top level.
`ifndef BLANK_SKIP_WRITE_SEGMENTER_CORE_ASSERT_SVH
`define BLANK_SKIP_WRITE_SEGMENTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define BSWS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segmenter check failed");

// Next-cycle implication, checked on clk, off during reset.
`define BSWS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segmenter check failed");

`endif

// ----- sv/bsws_pkg.sv -----
// Constants and types of the blank-skipping write segmenter.
`default_nettype none
package bsws_pkg;
	localparam int ADDR_BITS = 16;
	localparam int LEN_BITS = ADDR_BITS + 1;
	localparam logic [7:0] BLANK_BYTE = 8'hFF;
	localparam logic [7:0] GAP_RESET = 8'd8;
	localparam logic [7:0] RUN_MAX = 8'hFF;

	typedef struct packed {
		logic                 open;
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] last_data;
		logic [7:0]           blank_run;
	} seg_state_t;

	typedef struct packed {
		logic                 emit;
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  length;
	} seg_result_t;
endpackage
`default_nettype wire

// ----- sv/bsws_step.sv -----
// Per-byte segment tracking: next state and segment emission.
`default_nettype none
module bsws_step (
	input  wire bsws_pkg::seg_state_t             cur,
	input  wire logic [7:0]                       gap_threshold,
	input  wire logic [7:0]                       byte_value,
	input  wire logic [bsws_pkg::ADDR_BITS-1:0]   byte_address,
	input  wire logic                             last_byte,
	output bsws_pkg::seg_state_t                  nxt,
	output bsws_pkg::seg_result_t                 res
);
	import bsws_pkg::*;

	seg_state_t           mid;
	logic [7:0]           run_inc;
	logic                 gap_hit;
	logic [ADDR_BITS-1:0] span;

	always_comb begin
		mid = cur;
		gap_hit = 1'b0;
		run_inc = (cur.blank_run < RUN_MAX) ? cur.blank_run + 8'd1 : cur.blank_run;
		if (byte_value != BLANK_BYTE) begin
			mid.open = 1'b1;
			if (!cur.open) begin
				mid.start = byte_address;
			end
			mid.last_data = byte_address;
			mid.blank_run = '0;
		end else if (cur.open) begin
			mid.blank_run = run_inc;
			gap_hit = (run_inc >= gap_threshold);
		end
	end

	// Close on a long enough blank run, or flush whatever is open on the final byte.
	always_comb begin
		span = mid.last_data - mid.start;
		res.emit = gap_hit || (last_byte && mid.open);
		res.start = mid.start;
		res.length = LEN_BITS'(span) + LEN_BITS'(1);
		if (gap_hit || last_byte) begin
			nxt = '0;
		end else begin
			nxt = mid;
		end
	end
endmodule
`default_nettype wire

// ----- sv/blank_skip_write_segmenter_core.sv -----
// Top level of the blank-skipping write segmenter.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_stall     | byte_value, byte_address, last_byte
//  out     | output    | out_valid / out_stall   | segment_address, segment_length
//  cfg     | input     | cfg_write               | cfg_data (gap_threshold)
//
// One byte is accepted per cycle while in_stall is low; each byte is held in the input
// register and its segment, if any, enters the result register as the byte leaves.
// The rate is set by the state update, which bsws_step computes combinationally.
// Reset clears all segment state and loads the gap threshold with 8.
// A stalled result blocks only bytes that would emit another segment.
`default_nettype none
module blank_skip_write_segmenter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_value,
	input  wire logic [15:0] byte_address,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      segment_address,
	output logic [16:0]      segment_length
);
	import bsws_pkg::*;

	logic                 valid_s1;
	logic [7:0]           value_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 last_s1;
	logic [7:0]           gap_threshold_q;
	seg_state_t           state_q;
	seg_state_t           state_nxt;
	seg_result_t          step_res;
	logic                 adv_s1;
	logic                 out_valid_q;

	bsws_step u_step (
		.cur           (state_q),
		.gap_threshold (gap_threshold_q),
		.byte_value    (value_s1),
		.byte_address  (addr_s1),
		.last_byte     (last_s1),
		.nxt           (state_nxt),
		.res           (step_res)
	);

	assign adv_s1 = valid_s1 && (!step_res.emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= GAP_RESET;
		end else if (cfg_write) begin
			gap_threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			value_s1 <= byte_value;
			addr_s1 <= ADDR_BITS'(byte_address);
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			// drop the transaction once taken
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_res.emit) begin
			segment_address <= 16'(step_res.start);
			segment_length <= 17'(step_res.length);
		end
	end

`include "blank_skip_write_segmenter_core_assert.svh"

	`BSWS_ASSERT_IMP(a_idle_clean, !state_q.open, state_q.blank_run == '0 && state_q.start == '0 && state_q.last_data == '0)
	`BSWS_ASSERT_IMP(a_run_below_gap, state_q.open && state_q.blank_run != '0, state_q.blank_run < gap_threshold_q)
	`BSWS_ASSERT_IMP(a_len_nonzero, out_valid_q, segment_length != '0)
	`BSWS_ASSERT_IMP(a_stall_needs_item, in_stall, valid_s1 && out_valid_q && out_stall)
	`BSWS_ASSERT_NXT(a_held_item_stays, valid_s1 && !adv_s1, valid_s1)
endmodule
`default_nettype wire
